@@ sv/wpw_pkg.sv @@
// Shared types and constants for the 24-bit PCM WAV stream writer.
package wpw_pkg;

	localparam int HDR_BYTES = 44;
	localparam int SMP_BYTES = 3;
	localparam int QDEPTH    = 2;

	localparam logic       CMD_HEADER = 1'b0;
	localparam logic       CMD_SAMPLE = 1'b1;

	localparam logic [1:0] REG_CHANNELS = 2'd0;
	localparam logic [1:0] REG_RATE     = 2'd1;
	localparam logic [1:0] REG_FRAMES   = 2'd2;

	localparam logic [15:0] RST_CHANNELS = 16'd2;
	localparam logic [15:0] RST_ALIGN    = 16'd6;
	localparam logic [30:0] RST_RATE     = 31'd48000;
	localparam logic [31:0] RST_FRAMES   = 32'd0;

	localparam logic signed [25:0] FULL_POS = 26'sd8388608;
	localparam logic signed [25:0] FULL_NEG = -26'sd8388608;
	localparam logic [23:0]        PCM_MAX  = 24'h7FFFFF;
	localparam logic [23:0]        PCM_MIN  = 24'h800001;

	// one classified item waiting for the byte sequencer
	typedef struct packed {
		logic        is_sample;
		logic [23:0] pcm;
		logic [31:0] bytes_per_sec;
		logic [31:0] data_size;
	} entry_t;

	// configuration seen by front and back
	typedef struct packed {
		logic [15:0] channels;
		logic [30:0] rate_hz;
		logic [15:0] align;
	} cfg_t;

endpackage

@@ sv/wpw_front.sv @@
// Front end: accepts items, converts samples, computes header products.
module wpw_front
	import wpw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  cfg_t        cfg,
	input  logic [31:0] frames,
	input  logic        q_full,
	output logic        push,
	output entry_t      push_entry
);

	logic              valid_s1;
	entry_t            entry_s1;
	logic signed [25:0] smp;
	logic [23:0]       pcm;
	logic [47:0]       rate_prod;
	logic [47:0]       data_prod;
	logic              take;

	assign smp       = s_tdata[25:0];
	assign rate_prod = {17'd0, cfg.rate_hz} * {32'd0, cfg.align};
	assign data_prod = {16'd0, frames} * {32'd0, cfg.align};

	// clamp to full scale, then step one code toward zero
	always_comb begin
		priority if (smp > FULL_POS) begin
			pcm = PCM_MAX;
		end else if (smp < FULL_NEG) begin
			pcm = PCM_MIN;
		end else if (smp > 26'sd0) begin
			pcm = 24'(smp - 26'sd1);
		end else if (smp < 26'sd0) begin
			pcm = 24'(smp + 26'sd1);
		end else begin
			pcm = 24'd0;
		end
	end

	assign push       = valid_s1 && !q_full;
	assign push_entry = entry_s1;
	assign s_tready   = !valid_s1 || !q_full;
	assign take       = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.is_sample     <= (s_tuser[0] == CMD_SAMPLE);
			entry_s1.pcm           <= pcm;
			entry_s1.bytes_per_sec <= rate_prod[31:0];
			entry_s1.data_size     <= data_prod[31:0];
		end
	end

endmodule

@@ sv/wpw_fifo.sv @@
// Short queue between the front end and the byte sequencer.
module wpw_fifo
	import wpw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t head
);

	localparam int PW = $clog2(QDEPTH);

	entry_t          mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full      = (count_q == (PW+1)'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ sv/wpw_back.sv @@
// Back end: walks the queued item byte by byte into the output register.
module wpw_back
	import wpw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        not_empty,
	input  entry_t      head,
	input  cfg_t        cfg,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	logic [5:0]  idx_q;
	logic [7:0]  byte_d;
	logic        last_d;
	logic        load;
	logic [31:0] riff_size;

	assign riff_size = head.data_size + 32'd36;

	always_comb begin
		unique case (idx_q)
			6'd0:  byte_d = 8'h52;
			6'd1:  byte_d = 8'h49;
			6'd2:  byte_d = 8'h46;
			6'd3:  byte_d = 8'h46;
			6'd4:  byte_d = riff_size[7:0];
			6'd5:  byte_d = riff_size[15:8];
			6'd6:  byte_d = riff_size[23:16];
			6'd7:  byte_d = riff_size[31:24];
			6'd8:  byte_d = 8'h57;
			6'd9:  byte_d = 8'h41;
			6'd10: byte_d = 8'h56;
			6'd11: byte_d = 8'h45;
			6'd12: byte_d = 8'h66;
			6'd13: byte_d = 8'h6D;
			6'd14: byte_d = 8'h74;
			6'd15: byte_d = 8'h20;
			6'd16: byte_d = 8'h10;
			6'd20: byte_d = 8'h01;
			6'd22: byte_d = cfg.channels[7:0];
			6'd23: byte_d = cfg.channels[15:8];
			6'd24: byte_d = cfg.rate_hz[7:0];
			6'd25: byte_d = cfg.rate_hz[15:8];
			6'd26: byte_d = cfg.rate_hz[23:16];
			6'd27: byte_d = {1'b0, cfg.rate_hz[30:24]};
			6'd28: byte_d = head.bytes_per_sec[7:0];
			6'd29: byte_d = head.bytes_per_sec[15:8];
			6'd30: byte_d = head.bytes_per_sec[23:16];
			6'd31: byte_d = head.bytes_per_sec[31:24];
			6'd32: byte_d = cfg.align[7:0];
			6'd33: byte_d = cfg.align[15:8];
			6'd34: byte_d = 8'h18;
			6'd36: byte_d = 8'h64;
			6'd37: byte_d = 8'h61;
			6'd38: byte_d = 8'h74;
			6'd39: byte_d = 8'h61;
			6'd40: byte_d = head.data_size[7:0];
			6'd41: byte_d = head.data_size[15:8];
			6'd42: byte_d = head.data_size[23:16];
			6'd43: byte_d = head.data_size[31:24];
			default: byte_d = 8'h00;
		endcase
		if (head.is_sample) begin
			unique case (idx_q[1:0])
				2'd0:    byte_d = head.pcm[7:0];
				2'd1:    byte_d = head.pcm[15:8];
				default: byte_d = head.pcm[23:16];
			endcase
		end
	end

	assign last_d = head.is_sample ? (idx_q == 6'(SMP_BYTES - 1))
	                               : (idx_q == 6'(HDR_BYTES - 1));
	assign load   = not_empty && (!m_tvalid || m_tready);
	assign pop    = load && last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_d ? 6'd0 : idx_q + 6'd1;
			end
			if (load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= byte_d;
			m_tlast <= last_d;
		end
	end

endmodule

@@ sv/wav_pcm24_stream_writer.sv @@
// Top level of the 24-bit PCM WAV stream writer with its register file.
//
// Input stream: s_tuser[0] selects the command (header or sample), s_tdata
// carries the signed Q2.23 sample in its low 26 bits. Output stream: one
// file byte per item on m_tdata, m_tlast marks the final byte of each
// input item. A header item yields the 44-byte RIFF/WAVE header, a sample
// item yields three bytes, least significant first.
// Registers on the APB port: channel count at 0x0, sample rate at 0x4,
// frame count at 0x8; write them only while the stream is idle.
// An input item passes the front-end register and the queue, and each of its bytes
// is registered on the port. The back-end byte sequencer gives one output byte per
// cycle while the queue holds an item and m_tready is high.
// A two-entry queue between front end and sequencer lets input keep
// flowing while output stalls; when the receiver holds m_tready low the
// byte stays on the port, the queue fills and then s_tready drops.
// Reset clears the pipeline and queue and restores the register defaults
// (2 channels, 48000 Hz, 0 frames).
module wav_pcm24_stream_writer
	import wpw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [25:0] sample_value, [31:26] zero
	input  logic [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t        cfg_q;
	logic [31:0] frames_q;
	logic        wr_en;
	logic        push;
	entry_t      push_entry;
	logic        pop;
	logic        q_full;
	logic        q_not_empty;
	entry_t      head;
	logic [17:0] align_x3;

	assign pready   = 1'b1;
	assign wr_en    = psel && penable && pwrite && pready;
	assign align_x3 = {2'b00, pwdata[15:0]} + {1'b0, pwdata[15:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels <= RST_CHANNELS;
			cfg_q.align    <= RST_ALIGN;
			cfg_q.rate_hz  <= RST_RATE;
			frames_q       <= RST_FRAMES;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CHANNELS: begin
					cfg_q.channels <= pwdata[15:0];
					cfg_q.align    <= align_x3[15:0];
				end
				REG_RATE:   cfg_q.rate_hz <= pwdata[30:0];
				REG_FRAMES: frames_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CHANNELS: prdata = {16'd0, cfg_q.channels};
			REG_RATE:     prdata = {1'b0, cfg_q.rate_hz};
			REG_FRAMES:   prdata = frames_q;
			default:      prdata = 32'd0;
		endcase
	end

	wpw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cfg        (cfg_q),
		.frames     (frames_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	wpw_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	wpw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.head      (head),
		.cfg       (cfg_q),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ sv/wpw_checker.sv @@
// Port-level checks for the WAV stream writer, bound to the top level.
module wpw_checker
	import wpw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled output item changed");

	a_no_wait: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

	a_chan_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[3:2] == REG_CHANNELS)
		##1 (psel && !pwrite && paddr[3:2] == REG_CHANNELS)
		|-> prdata == {16'd0, $past(pwdata[15:0])})
		else $error("channel count readback mismatch");

	a_rate_width: assert property (@(posedge clk) disable iff (!arst_n)
		paddr[3:2] == REG_RATE |-> !prdata[31])
		else $error("sample rate register wider than 31 bits");

endmodule

bind wav_pcm24_stream_writer wpw_checker u_wpw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready)
);
